/* design/brlc_pkg.sv */
// ----------------------------------------------------------------------------
// brlc_pkg
// Shared types and constants for the block-read LRU cache policy.
// ----------------------------------------------------------------------------
package brlc_pkg;

  localparam int TAG_W   = 18;
  localparam int CNT_W   = 16;
  localparam int OFF_W   = 24;
  localparam int LEN_W   = 16;
  localparam int SHIFT_W = 4;
  localparam int ACT_W   = 5;
  localparam int START_W = 12;
  localparam int CLEN_W  = 13;
  localparam int OSLOT_W = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd6;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd9;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;

  localparam logic REG_SHIFT  = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  typedef struct packed {
    logic init;
    logic start;
    logic lookup;
    logic update;
    logic scan_init;
    logic scan_step;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic too_many;
    logic hit;
    logic need_scan;
    logic scan_done;
    logic last_blk;
  } sts_t;

endpackage

/* design/brlc_datapath.sv */
// ----------------------------------------------------------------------------
// brlc_datapath
// Slot tags, counts, recency ranks, block walk and most-accessed tracking.
// ----------------------------------------------------------------------------
module brlc_datapath #(
  parameter int SLOTS = 16,
  parameter int MAXB  = 64
) (
  input  logic                          clk,
  input  brlc_pkg::cmd_t                cmd,
  output brlc_pkg::sts_t                sts,
  input  logic [brlc_pkg::SHIFT_W-1:0]  shift_cfg,
  input  logic [brlc_pkg::ACT_W-1:0]    act_cfg,
  input  logic [brlc_pkg::OFF_W-1:0]    in_off,
  input  logic [brlc_pkg::LEN_W-1:0]    in_len,
  output logic [brlc_pkg::TAG_W-1:0]    o_block,
  output logic [brlc_pkg::OSLOT_W-1:0]  o_slot,
  output logic                          o_hit,
  output logic [brlc_pkg::START_W-1:0]  o_start,
  output logic [brlc_pkg::CLEN_W-1:0]   o_len,
  output logic [brlc_pkg::OSLOT_W-1:0]  o_top,
  output logic                          o_last
);
  import brlc_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);

  logic [TAG_W-1:0] tag_r [SLOTS];
  logic [SLOTS-1:0] val_r;
  logic [CNT_W-1:0] cnt_r [SLOTS];
  logic [SW-1:0]    rank_r [SLOTS];
  logic [SW-1:0]    top_r;
  logic [CNT_W-1:0] topc_r;

  logic [SHIFT_W-1:0] sh;
  logic [NW-1:0]      n;
  logic [NW-1:0]      act_ext;
  always_comb begin
    sh = shift_cfg;
    if (sh < SHIFT_MIN) sh = SHIFT_MIN;
    if (sh > SHIFT_MAX) sh = SHIFT_MAX;
    act_ext = (ACT_W >= NW) ? NW'(act_cfg) : NW'(act_cfg);
    n = act_ext;
    if ({27'd0, act_cfg} < 32'd2) n = NW'(2);
    if ({27'd0, act_cfg} > 32'(SLOTS)) n = NW'(SLOTS);
  end

  logic [OFF_W:0] cur_r, last_r, off_r, endb_r;
  logic [OFF_W:0] endb, firstb, lastb, nblk;
  always_comb begin
    endb   = {1'b0, in_off} + {9'd0, in_len} - 25'd1;
    firstb = {1'b0, in_off} >> sh;
    lastb  = endb >> sh;
    nblk   = lastb - firstb + 25'd1;
  end

  logic [TAG_W-1:0] tag_cur;
  assign tag_cur = cur_r[TAG_W-1:0];

  logic             fnd_r, hit_sel;
  logic [SW-1:0]    hs_r, vic_r, sel_r;
  logic [SLOTS-1:0] match;
  logic [SW-1:0]    hs, vs;
  logic             hf;
  always_comb begin
    hf = 1'b0; hs = '0; vs = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (NW'(i) < n) && val_r[i] && (tag_r[i] == tag_cur);
      if (match[i] && !hf) begin
        hf = 1'b1; hs = SW'(i);
      end
      if ((NW'(i) < n) && rank_r[i] == '0) vs = SW'(i);
    end
  end
  assign hit_sel = fnd_r;

  logic [SW-1:0] srank_r;
  logic          sdone_r;

  logic [OFF_W:0] bstart, bend, lo, hi;
  always_comb begin
    bstart = cur_r << sh;
    bend   = bstart + (25'd1 << sh) - 25'd1;
    lo     = (off_r > bstart) ? off_r : bstart;
    hi     = (endb_r < bend) ? endb_r : bend;
  end

  logic [CNT_W-1:0] newc;
  logic [SW-1:0]    s;
  always_comb begin
    s    = fnd_r ? hs_r : vic_r;
    newc = fnd_r ? ((cnt_r[hs_r] < CNT_MAX) ? cnt_r[hs_r] + 16'd1 : cnt_r[hs_r]) : 16'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      val_r  <= '0;
      topc_r <= '0;
      top_r  <= SW'(n - NW'(1));
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i]  <= '0;
        rank_r[i] <= SW'(i);
      end
    end else begin
      if (cmd.start) begin
        cur_r  <= firstb;
        last_r <= lastb;
        off_r  <= {1'b0, in_off};
        endb_r <= endb;
      end
      if (cmd.lookup) begin
        fnd_r <= hf;
        hs_r  <= hs;
        vic_r <= vs;
      end
      if (cmd.update) begin
        for (int i = 0; i < SLOTS; i++)
          if ((NW'(i) < n) && rank_r[i] > rank_r[s]) rank_r[i] <= rank_r[i] - SW'(1);
        rank_r[s] <= SW'(n - NW'(1));
        cnt_r[s]  <= newc;
        sel_r     <= s;
        o_start   <= START_W'(lo - bstart);
        o_len     <= CLEN_W'(hi - lo + 25'd1);
        if (!fnd_r) begin
          tag_r[s] <= tag_cur;
          val_r[s] <= 1'b1;
        end
        if (cmd.scan_init) begin
          topc_r <= '0;
        end else if (newc >= topc_r) begin
          topc_r <= newc;
          top_r  <= s;
        end
      end
      if (cmd.scan_init) begin
        srank_r <= SW'(n - NW'(1));
        sdone_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        for (int i = 0; i < SLOTS; i++)
          if ((NW'(i) < n) && rank_r[i] == srank_r && cnt_r[i] > topc_r) begin
            topc_r <= cnt_r[i];
            top_r  <= SW'(i);
          end
        srank_r <= srank_r - SW'(1);
        sdone_r <= (srank_r == '0);
      end
      if (cmd.advance) cur_r <= cur_r + 25'd1;
    end
  end

  assign sts.too_many  = nblk > 25'(MAXB);
  assign sts.hit       = hit_sel;
  assign sts.need_scan = !fnd_r && (vic_r == top_r);
  assign sts.scan_done = sdone_r;
  assign sts.last_blk  = (cur_r == last_r);

  assign o_block = tag_cur;
  assign o_slot  = OSLOT_W'(sel_r);
  assign o_hit   = fnd_r;
  assign o_top   = OSLOT_W'(top_r);
  assign o_last  = (cur_r == last_r);
endmodule

/* design/brlc_ctrl.sv */
// ----------------------------------------------------------------------------
// brlc_ctrl
// Sequencer: per block lookup, update, optional rescan, then output; requests with too many blocks fail.
// ----------------------------------------------------------------------------
module brlc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_zero,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_fail,
  output brlc_pkg::cmd_t cmd,
  input  brlc_pkg::sts_t sts
);
  import brlc_pkg::*;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOOK   = 7'b0000100,
    S_UPD    = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_OUT    = 7'b0100000,
    S_FAIL   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    out_fail = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !in_zero) begin
          cmd.start = 1'b1;
          state_nxt = sts.too_many ? S_FAIL : S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (sts.need_scan) begin
          cmd.scan_init = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_step = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.last_blk) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt = S_LOOK;
          end
        end
      end
      S_FAIL: begin
        out_valid = 1'b1;
        out_fail = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
    if (cfg_wr) state_nxt = S_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* design/block_read_lru_cache_policy_top.sv */
// Each block passes through the lookup, update and output states, with a
// rank-ordered rescan loop added when the evicted slot was the most-accessed one.
// One request is taken at a time; the input stalls until every block of the
// request has been output, and output stalls hold the sequencer.
// Reset: synchronous active low; the init state restores cache state, and a
// register write also sends the sequencer back through the init state.
// ----------------------------------------------------------------------------
// block_read_lru_cache_policy_top
// Splits read requests into blocks and runs LRU slot policy per block.
// ----------------------------------------------------------------------------
module block_read_lru_cache_policy_top #(
  parameter int SLOTS = 16,
  parameter int MAX_BLOCKS_PER_READ = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [brlc_pkg::ACT_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brlc_pkg::OFF_W-1:0]    in_byte_offset,
  input  logic [brlc_pkg::LEN_W-1:0]    in_byte_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brlc_pkg::TAG_W-1:0]    out_block_index,
  output logic [brlc_pkg::OSLOT_W-1:0]  out_slot,
  output logic                          out_hit,
  output logic [brlc_pkg::START_W-1:0]  out_copy_start,
  output logic [brlc_pkg::CLEN_W-1:0]   out_copy_len,
  output logic [brlc_pkg::OSLOT_W-1:0]  out_top_slot,
  output logic                          out_is_last,
  output logic                          out_failed
);
  import brlc_pkg::*;

  logic [SHIFT_W-1:0] shift_r;
  logic [ACT_W-1:0]   act_r;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr, fail;
  logic [TAG_W-1:0] blk;
  logic [OSLOT_W-1:0] sl, tp;
  logic hh, ll;
  logic [START_W-1:0] cs;
  logic [CLEN_W-1:0] cl;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RST;
      act_r   <= ACT_W'(16);
    end else if (cfg_wr) begin
      if (cfg_index == REG_SHIFT) shift_r <= cfg_data[SHIFT_W-1:0];
      else act_r <= cfg_data;
    end
  end

  brlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_wr(cfg_wr), .in_valid(in_valid),
    .in_stall(in_stall), .in_zero(in_byte_count == '0), .out_valid(out_valid),
    .out_stall(out_stall), .out_fail(fail), .cmd(cmd), .sts(sts)
  );

  brlc_datapath #(.SLOTS(SLOTS), .MAXB(MAX_BLOCKS_PER_READ)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .shift_cfg(shift_r), .act_cfg(act_r),
    .in_off(in_byte_offset), .in_len(in_byte_count), .o_block(blk), .o_slot(sl),
    .o_hit(hh), .o_start(cs), .o_len(cl), .o_top(tp), .o_last(ll)
  );

  assign out_block_index = fail ? '0 : blk;
  assign out_slot        = fail ? '0 : sl;
  assign out_hit         = fail ? 1'b0 : hh;
  assign out_copy_start  = fail ? '0 : cs;
  assign out_copy_len    = fail ? '0 : cl;
  assign out_top_slot    = tp;
  assign out_is_last     = fail ? 1'b1 : ll;
  assign out_failed      = fail;

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failed |-> out_is_last) else $error("fail not last");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while output pending");
endmodule
